// File: rtl/rgasd_pkg.sv
// shared types and constants for the run-length glyph alpha span decoder
// no dependencies; imported by every module of the block
`default_nettype none

package rgasd_pkg;

  localparam int unsigned CODE_W     = 8;   // one coded byte
  localparam int unsigned NIB_W      = 4;   // one 4-bit pixel
  localparam int unsigned ALPHA_W    = 8;   // scaled alpha
  localparam int unsigned RUN_W      = 7;   // run length field of a header
  localparam int unsigned LEFT_W     = 8;   // bytes or pairs still owed (0..128)
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned HDR_REP_BIT = 7;  // set: repeat run, clear: literal run

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LEFT   = 3'd0,
    CFG_CLIP_RIGHT  = 3'd1,
    CFG_CLIP_TOP    = 3'd2,
    CFG_CLIP_BOTTOM = 3'd3,
    CFG_COL_OFFSET  = 3'd4,
    CFG_SKIP_ROWS   = 3'd5,
    CFG_ROW_LENGTH  = 3'd6,
    CFG_BRUSH_ALPHA = 3'd7
  } cfg_idx_e;

  // status of one clipped span
  typedef struct packed {
    logic hit;  // some column of the span is inside the window
    logic odd;  // first visible column is the high nibble of a pair
  } span_flags_t;

endpackage

`default_nettype wire

// File: rtl/rgasd_alpha_scale.sv
// scales one 4-bit pixel to 8-bit alpha and multiplies in the brush alpha
// depends on rgasd_pkg
`default_nettype none

module rgasd_alpha_scale (
  input  logic [rgasd_pkg::NIB_W-1:0]   nib_i,
  input  logic [rgasd_pkg::ALPHA_W-1:0] brush_i,
  output logic [rgasd_pkg::ALPHA_W-1:0] alpha_o
);
  import rgasd_pkg::*;

  logic [2*ALPHA_W-1:0] prod;
  logic [2*ALPHA_W-1:0] sum;

  // n*17 is the nibble repeated in both halves of a byte
  assign prod = (2*ALPHA_W)'({nib_i, nib_i}) * (2*ALPHA_W)'(brush_i);
  // floor(x/255) for x below 2^16: (x + 1 + (x >> 8)) >> 8, cannot overflow here
  assign sum     = prod + (2*ALPHA_W)'(1) + {{ALPHA_W{1'b0}}, prod[2*ALPHA_W-1:ALPHA_W]};
  assign alpha_o = sum[2*ALPHA_W-1:ALPHA_W];

endmodule

`default_nettype wire

// File: rtl/rgasd_span_clip.sv
// places the pixel run of one data byte on the screen row and clips it to the window
// depends on rgasd_pkg
`default_nettype none

module rgasd_span_clip #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic [COORD_WIDTH-1:0]        clip_left_i,
  input  logic [COORD_WIDTH-1:0]        clip_right_i,
  input  logic [COORD_WIDTH-1:0]        col_offset_i,
  input  logic [COORD_WIDTH+1:0]        column_pos_i,
  input  logic [rgasd_pkg::LEFT_W-1:0]  pairs_i,
  output logic [COORD_WIDTH-1:0]        first_o,
  output logic [COORD_WIDTH-1:0]        last_o,
  output rgasd_pkg::span_flags_t        flags_o
);
  import rgasd_pkg::*;

  localparam int unsigned SW = COORD_WIDTH + 4;

  logic signed [SW-1:0] left_s;
  logic signed [SW-1:0] right_s;
  logic signed [SW-1:0] start_s;
  logic signed [SW-1:0] end_s;
  logic signed [SW-1:0] first_s;
  logic signed [SW-1:0] last_s;

  always_comb begin
    left_s  = $signed(SW'(clip_left_i));
    right_s = $signed(SW'(clip_right_i));
    start_s = left_s - $signed(SW'(col_offset_i)) + $signed(SW'(column_pos_i));
    end_s   = start_s + $signed(SW'({pairs_i, 1'b0})) - $signed(SW'(1'b1));
    first_s = (start_s > left_s) ? start_s : left_s;
    last_s  = (end_s < right_s) ? end_s : right_s;
    flags_o.hit = (first_s <= last_s);
    flags_o.odd = first_s[0] ^ start_s[0];
    first_o = first_s[COORD_WIDTH-1:0];
    last_o  = last_s[COORD_WIDTH-1:0];
  end

endmodule

`default_nettype wire

// File: rtl/rle_glyph_alpha_span_decoder.sv
// top level: input register, decoder position state, span and alpha logic, result register
// depends on rgasd_pkg, rgasd_span_clip, rgasd_alpha_scale
//
//  channel | beat fields (low bit up)                                  | handshake
//  --------+-----------------------------------------------------------+-----------------
//  s_axis  | tdata: code_byte; tuser: glyph_start                      | tvalid/tready
//  m_axis  | tdata: span_row, span_first, span_last, alpha_at_first,   | tvalid/tready
//          |        alpha_at_next, zero pad                            |
//  cfg     | cfg_idx_i selects register, cfg_wdata_i value             | cfg_we_i, no wait
//
// one coded byte per cycle unless m_axis stalls; a byte waits in the input register and its
// span, if any, is written to the result register as the byte leaves the input register.
// the rate is set by the position update, which sees every byte in order.
// reset returns the decoder to header-expected at column zero and the registers to their
// defaults. a stalled m_axis holds the result and the input register, and s_axis_tready
// falls only while both are full.
`default_nettype none

module rle_glyph_alpha_span_decoder #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [rgasd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]              cfg_wdata_i,
  // coded byte stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rgasd_pkg::CODE_W-1:0]        s_axis_tdata,  // code_byte
  input  logic [0:0]                          s_axis_tuser,  // glyph_start
  // span stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // span_row, span_first, span_last, alpha_at_first, alpha_at_next, zero pad
  output logic [((3*COORD_WIDTH+2*rgasd_pkg::ALPHA_W+7)/8)*8-1:0] m_axis_tdata
);
  import rgasd_pkg::*;

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned COLW   = COORD_WIDTH + 2;
  localparam int unsigned PAY_W  = 3*CW + 2*ALPHA_W;
  localparam int unsigned DATA_W = ((PAY_W + 7) / 8) * 8;

  // configuration registers
  logic [CW-1:0]      clip_left_q, clip_right_q, clip_top_q, clip_bottom_q;
  logic [CW-1:0]      col_offset_q, skip_rows_q, row_length_q;
  logic [ALPHA_W-1:0] brush_alpha_q;

  // input register
  logic              in_valid_q;
  logic [CODE_W-1:0] byte_q;
  logic              gs_q;

  // decoder position state
  logic              expect_q, expect_d;
  logic              rep_q, rep_d;
  logic [LEFT_W-1:0] left_q, left_d;
  logic [COLW-1:0]   col_q, col_d;
  logic [CW-1:0]     rskip_q, rskip_d;
  logic [CW-1:0]     srow_q, srow_d;
  logic              fin_q, fin_d;

  // result register
  logic             out_valid_q;
  logic [PAY_W-1:0] out_pay_q;

  logic              adv;
  logic              emit;
  logic [LEFT_W-1:0] pairs;
  logic [COLW-1:0]   col_cur;
  logic [CW-1:0]     first, last;
  span_flags_t       flags;
  logic [ALPHA_W-1:0] a_lo, a_hi;

  // effective state after a glyph start
  logic              e_expect, e_rep, e_fin;
  logic [LEFT_W-1:0] e_left;
  logic [COLW-1:0]   e_col;
  logic [CW-1:0]     e_rskip, e_srow;
  logic              visible;
  logic [CW-1:0]     rskip_inc;
  logic [COLW-1:0]   col_sum;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= '0;
      clip_right_q  <= '0;
      clip_top_q    <= '0;
      clip_bottom_q <= '0;
      col_offset_q  <= '0;
      skip_rows_q   <= '0;
      row_length_q  <= CW'(1);
      brush_alpha_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CLIP_LEFT:   clip_left_q   <= cfg_wdata_i;
        CFG_CLIP_RIGHT:  clip_right_q  <= cfg_wdata_i;
        CFG_CLIP_TOP:    clip_top_q    <= cfg_wdata_i;
        CFG_CLIP_BOTTOM: clip_bottom_q <= cfg_wdata_i;
        CFG_COL_OFFSET:  col_offset_q  <= cfg_wdata_i;
        CFG_SKIP_ROWS:   skip_rows_q   <= cfg_wdata_i;
        CFG_ROW_LENGTH:  row_length_q  <= cfg_wdata_i;
        CFG_BRUSH_ALPHA: brush_alpha_q <= cfg_wdata_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      byte_q <= s_axis_tdata;
      gs_q   <= s_axis_tuser[0];
    end
  end

  always_comb begin
    e_expect = gs_q ? 1'b1 : expect_q;
    e_rep    = gs_q ? 1'b0 : rep_q;
    e_left   = gs_q ? '0 : left_q;
    e_col    = gs_q ? '0 : col_q;
    e_rskip  = gs_q ? '0 : rskip_q;
    e_srow   = gs_q ? clip_top_q : srow_q;
    e_fin    = gs_q ? 1'b0 : fin_q;
    visible  = (e_rskip >= skip_rows_q);
    pairs    = e_rep ? e_left : LEFT_W'(1);
    col_cur  = e_col;
    col_sum  = e_col + COLW'({pairs, 1'b0});
    rskip_inc = e_rskip + CW'(1);

    expect_d = e_expect;
    rep_d    = e_rep;
    left_d   = e_left;
    col_d    = e_col;
    rskip_d  = e_rskip;
    srow_d   = e_srow;
    fin_d    = e_fin;
    emit     = 1'b0;

    priority if (e_fin) begin
      // bytes after the bottom row are dropped
    end else if (visible && (e_srow > clip_bottom_q)) begin
      fin_d = 1'b1;
    end else if (e_expect) begin
      rep_d    = byte_q[HDR_REP_BIT];
      left_d   = LEFT_W'(byte_q[RUN_W-1:0]) + LEFT_W'(1);
      expect_d = 1'b0;
    end else begin
      left_d = e_rep ? '0 : e_left - LEFT_W'(1);
      emit   = visible && (brush_alpha_q != '0) && flags.hit;
      col_d  = col_sum;
      if (left_d == '0) begin
        expect_d = 1'b1;
        // row end is only checked once the whole run is placed
        if (col_sum >= COLW'(row_length_q)) begin
          col_d = '0;
          if (!visible) begin
            rskip_d = rskip_inc;
            if (rskip_inc >= skip_rows_q) begin
              srow_d = clip_top_q;
            end
          end else if (e_srow >= clip_bottom_q) begin
            fin_d = 1'b1;
          end else begin
            srow_d = e_srow + CW'(1);
          end
        end
      end
    end
  end

  rgasd_span_clip #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_clip (
    .clip_left_i  (clip_left_q),
    .clip_right_i (clip_right_q),
    .col_offset_i (col_offset_q),
    .column_pos_i (col_cur),
    .pairs_i      (pairs),
    .first_o      (first),
    .last_o       (last),
    .flags_o      (flags)
  );

  rgasd_alpha_scale u_alpha_lo (
    .nib_i   (byte_q[NIB_W-1:0]),
    .brush_i (brush_alpha_q),
    .alpha_o (a_lo)
  );

  rgasd_alpha_scale u_alpha_hi (
    .nib_i   (byte_q[CODE_W-1:NIB_W]),
    .brush_i (brush_alpha_q),
    .alpha_o (a_hi)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b1;
      rep_q    <= 1'b0;
      left_q   <= '0;
      col_q    <= '0;
      rskip_q  <= '0;
      srow_q   <= '0;
      fin_q    <= 1'b0;
    end else if (adv) begin
      expect_q <= expect_d;
      rep_q    <= rep_d;
      left_q   <= left_d;
      col_q    <= col_d;
      rskip_q  <= rskip_d;
      srow_q   <= srow_d;
      fin_q    <= fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_pay_q <= {flags.odd ? a_lo : a_hi,
                    flags.odd ? a_hi : a_lo,
                    last, first, e_srow};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DATA_W'(out_pay_q);

endmodule

`default_nettype wire

// File: dv/glyph_span_checker.sv
// span checker for the run-length glyph alpha span decoder: follows register writes and
// accepted coded bytes, predicts each clipped span and compares it with the m_axis beats
// depends on rgasd_pkg
module glyph_span_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rgasd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [11:0]                   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // code_byte
  input  logic [0:0]                    s_axis_tuser,  // glyph_start
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // span_row, span_first, span_last, alpha_at_first, alpha_at_next, zero pad
  input  logic [55:0]                   m_axis_tdata,
  output int                            errors_o,
  output int                            pending_o,
  output int                            spans_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rgasd_pkg::*;

  // declared high field first so that row lands in the low bits
  typedef struct packed {
    logic [7:0]  alpha_next;
    logic [7:0]  alpha_first;
    logic [11:0] col_last;
    logic [11:0] col_first;
    logic [11:0] row;
  } span_t;

  logic [11:0] clip_l, clip_r, clip_t, clip_b, col_off, skip_n, row_len;
  logic [7:0]  brush;

  logic        hdr_due, rep_run, glyph_done;
  int          owed;
  logic [13:0] col;
  logic [11:0] rows_done, scr_row;

  span_t span_q[$];
  int    n_mism  = 0;
  int    n_spans = 0;

  assign errors_o = n_mism;
  assign spans_o  = n_spans;

  function automatic logic [7:0] scaled(input logic [3:0] nib);
    return 8'((int'(nib) * 17 * int'(brush)) / 255);
  endfunction

  task automatic restart_glyph();
    hdr_due    = 1'b1;
    rep_run    = 1'b0;
    owed       = 0;
    col        = '0;
    rows_done  = '0;
    scr_row    = clip_t;
    glyph_done = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic gs);
    int    pairs, head, tail, lo_col, hi_col;
    logic  vis, odd;
    logic [7:0] a_lo, a_hi;
    span_t s;
    if (gs) restart_glyph();
    if (glyph_done) return;
    vis = rows_done >= skip_n;
    if (vis && scr_row > clip_b) begin
      glyph_done = 1'b1;
      return;
    end
    if (hdr_due) begin
      rep_run = b[HDR_REP_BIT];
      owed    = int'(b[6:0]) + 1;
      hdr_due = 1'b0;
      return;
    end
    if (rep_run) begin
      pairs = owed;
      owed  = 0;
    end else begin
      pairs = 1;
      owed  = owed - 1;
    end
    if (vis && brush != 8'd0) begin
      head   = int'(clip_l) - int'(col_off) + int'(col);
      tail   = head + 2 * pairs - 1;
      lo_col = (head > int'(clip_l)) ? head : int'(clip_l);
      hi_col = (tail < int'(clip_r)) ? tail : int'(clip_r);
      if (lo_col <= hi_col) begin
        // an odd offset means the first visible column is a high nibble
        odd           = ((lo_col - head) & 1) != 0;
        a_lo          = scaled(b[3:0]);
        a_hi          = scaled(b[7:4]);
        s.row         = scr_row;
        s.col_first   = 12'(lo_col);
        s.col_last    = 12'(hi_col);
        s.alpha_first = odd ? a_hi : a_lo;
        s.alpha_next  = odd ? a_lo : a_hi;
        span_q.push_back(s);
      end
    end
    col = 14'(int'(col) + 2 * pairs);
    // row end is only looked at once a whole run is through
    if (owed == 0) begin
      hdr_due = 1'b1;
      if (col >= 14'(row_len)) begin
        col = '0;
        if (!vis) begin
          rows_done = rows_done + 12'd1;
          if (rows_done >= skip_n) scr_row = clip_t;
        end else if (scr_row >= clip_b) begin
          glyph_done = 1'b1;
        end else begin
          scr_row = scr_row + 12'd1;
        end
      end
    end
  endtask

  task automatic report(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      n_mism++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    span_t got, want;
    if (!rst_ni) begin
      clip_l  = '0;
      clip_r  = '0;
      clip_t  = '0;
      clip_b  = '0;
      col_off = '0;
      skip_n  = '0;
      row_len = 12'd1;
      brush   = 8'd255;
      span_q.delete();
      restart_glyph();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CLIP_LEFT:   clip_l  = cfg_wdata_i;
          CFG_CLIP_RIGHT:  clip_r  = cfg_wdata_i;
          CFG_CLIP_TOP:    clip_t  = cfg_wdata_i;
          CFG_CLIP_BOTTOM: clip_b  = cfg_wdata_i;
          CFG_COL_OFFSET:  col_off = cfg_wdata_i;
          CFG_SKIP_ROWS:   skip_n  = cfg_wdata_i;
          CFG_ROW_LENGTH:  row_len = cfg_wdata_i;
          CFG_BRUSH_ALPHA: brush   = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tuser[0]);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[51:0];
        if (span_q.size() == 0) begin
          n_mism++;
          $display("%0t: span beat expected none, got row %0d cols %0d..%0d alpha %0d/%0d",
                   $time, got.row, got.col_first, got.col_last, got.alpha_first,
                   got.alpha_next);
        end else begin
          want = span_q.pop_front();
          n_spans++;
          report("span_row", want.row, got.row);
          report("span_first", want.col_first, got.col_first);
          report("span_last", want.col_last, got.col_last);
          report("alpha_at_first", want.alpha_first, got.alpha_first);
          report("alpha_at_next", want.alpha_next, got.alpha_next);
        end
      end
      pending_o <= span_q.size();
    end
  end

endmodule

// File: dv/tb_top.sv
// testbench top for the run-length glyph alpha span decoder: clock, reset, register
// settings, coded byte stimulus and span back-pressure; checking sits in glyph_span_checker
// depends on rgasd_pkg, rle_glyph_alpha_span_decoder and glyph_span_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rgasd_pkg::*;

  localparam int CW      = 12;
  localparam int TDATA_W = ((3 * CW + 2 * ALPHA_W + 7) / 8) * 8;
  localparam int LIMIT   = 200000;
  localparam int HOLD    = 300;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CW-1:0]        cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [CODE_W-1:0]    s_axis_tdata  = '0;  // code_byte
  logic [0:0]           s_axis_tuser  = '0;  // glyph_start
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;  // span_row, span_first, span_last, alpha x2, pad

  int   mism, pending, spans;
  int   n_bytes    = 0;
  int   n_settings = 0;
  int   cycles     = 0;
  int   hold_left  = 0;
  logic calm       = 1'b0;
  logic hold_req   = 1'b0;
  logic hold_done  = 1'b0;

  rle_glyph_alpha_span_decoder #(.COORD_WIDTH(CW)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  glyph_span_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(mism), .pending_o(pending), .spans_o(spans)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // span sink: random stalls, one long hold-off on request, none while calm
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left     <= HOLD;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 36);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic gs);
    if (!calm) begin
      while ($urandom_range(99) < 36) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= gs;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_bytes++;
  endtask

  // wait for every predicted span, then let the pipeline run dry
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CW'(val);
    @(posedge clk_i);
  endtask

  task automatic program_window(input int l, input int r, input int t, input int b,
                                input int off, input int skip, input int len, input int br);
    write_reg(CFG_CLIP_LEFT, l);
    write_reg(CFG_CLIP_RIGHT, r);
    write_reg(CFG_CLIP_TOP, t);
    write_reg(CFG_CLIP_BOTTOM, b);
    write_reg(CFG_COL_OFFSET, off);
    write_reg(CFG_SKIP_ROWS, skip);
    write_reg(CFG_ROW_LENGTH, len);
    write_reg(CFG_BRUSH_ALPHA, br);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic pick_window(input int kind);
    int l, r, t, b, br;
    case (kind)
      0: program_window(0, 4095, 0, 4095, 0, 0, 4095, 255);        // one endless row
      1: program_window(4095, 4095, 4095, 4095, 0, 0, 1, 255);     // single-column corner
      2: program_window(0, 4095, 0, 4095, 0, 0, 8, 0);             // nothing drawn
      3: program_window(200, 100, 0, 4095, 0, 0, 8, 255);          // inverted window
      4: program_window(0, 63, 10, 40, 3, 2, 0, 128);              // zero row length
      5: program_window(0, 4095, 0, 4095, 4095, 4095, 16, 1);      // rows never reached
      6: program_window(0, 4095, 0, 4095, 0, 0, 16, 200);          // every data byte draws
      default: begin
        l = $urandom_range(0, 300);
        r = ($urandom_range(7) == 0) ? $urandom_range(0, l) : l + $urandom_range(0, 120);
        t = $urandom_range(0, 4000);
        b = ($urandom_range(7) == 0) ? $urandom_range(0, t) : t + $urandom_range(0, 8);
        case ($urandom_range(7))
          0:       br = 0;
          1:       br = 255;
          default: br = $urandom_range(1, 254);
        endcase
        program_window(l, r, t, b, $urandom_range(0, 60), $urandom_range(0, 3),
                       $urandom_range(1, 40), br);
      end
    endcase
  endtask

  // mostly well-formed glyphs with random pixels, some raw noise
  task automatic send_glyph();
    int   runs, len;
    logic rep;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom), $urandom_range(7) == 0);
    end else begin
      runs = $urandom_range(2, 16);
      for (int k = 0; k < runs; k++) begin
        len = ($urandom_range(15) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
        rep = $urandom_range(1);
        send_byte({rep, 7'(len)}, k == 0);
        if (rep) send_byte(8'($urandom), 1'b0);
        else repeat (len + 1) send_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  // {glyph_start, code_byte}: skipped row, clipped repeat, glyph end, ignored bytes, restart
  logic [8:0] intro [21] = '{
    9'h102, 9'h012, 9'h034, 9'h056,
    9'h080, 9'h0f0, 9'h001, 9'h00f, 9'h0ff,
    9'h085, 9'h0a5, 9'h000, 9'h07f,
    9'h1ff, 9'h03c, 9'h000, 9'h0ff,
    9'h081, 9'h000, 9'h080, 9'h09c
  };

  initial begin
    int kind, budget;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_window(2, 13, 3, 4, 1, 1, 6, 255);
    foreach (intro[i]) send_byte(intro[i][7:0], intro[i][8]);

    kind = 0;
    while (n_bytes < 1250) begin
      settle();
      calm <= (kind == 7);
      pick_window(kind);
      hold_req <= (kind == 6);
      budget = n_bytes + 100;
      while (n_bytes < budget) send_glyph();
      kind++;
    end
    settle();

    $display("%0d coded bytes under %0d window settings, %0d spans compared",
             n_bytes, n_settings, spans);
    $display("covered skips, clipping, brush scaling, glyph restarts and a %0d-cycle stall",
             HOLD);
    if (mism == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
